FILE: sv/rinq_pkg.sv
// ----------------------------------------------------------------------------
// rinq_pkg
// Shared types and constants of the range-image neighbor query unit.
// ----------------------------------------------------------------------------
package rinq_pkg;

    localparam int COLUMNS_DEFAULT = 256;
    localparam int ROWS_DEFAULT    = 128;

    localparam int DEPTH_W  = 18;
    localparam int CELL_W   = 1 + 2 * DEPTH_W;
    localparam int KIND_W   = 2;
    localparam int COL_IN_W = 9;
    localparam int ROW_IN_W = 8;
    localparam int FOV_W    = 7;
    localparam int RADIUS_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_VERT  = 2'd1,
        KIND_RANGE = 2'd2
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 2'd2;

    localparam logic [FOV_W-1:0]    FLOOR_RESET   = 7'd0;
    localparam logic [FOV_W-1:0]    CEILING_RESET = 7'd127;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET  = 4'd1;

    typedef struct packed {
        logic clear;
        logic en;
    } acc_ctl_t;

endpackage

FILE: sv/rinq_ram.sv
// ----------------------------------------------------------------------------
// rinq_ram
// Single-port RAM with one write or read per cycle and registered read data.
// ----------------------------------------------------------------------------
module rinq_ram #(
    parameter int WIDTH = rinq_pkg::CELL_W,
    parameter int DEPTH = rinq_pkg::COLUMNS_DEFAULT * rinq_pkg::ROWS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/rinq_acc.sv
// ----------------------------------------------------------------------------
// rinq_acc
// Compare unit: running minimum of near depths and maximum of far
// depths over the occupied cells returned by a window scan.
// ----------------------------------------------------------------------------
module rinq_acc (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rinq_pkg::acc_ctl_t            ctl,
    input  logic [rinq_pkg::DEPTH_W-1:0]  near_in,
    input  logic [rinq_pkg::DEPTH_W-1:0]  far_in,
    output logic                          found,
    output logic [rinq_pkg::DEPTH_W-1:0]  lo,
    output logic [rinq_pkg::DEPTH_W-1:0]  hi
);

    logic                         found_reg;
    logic [rinq_pkg::DEPTH_W-1:0] lo_reg;
    logic [rinq_pkg::DEPTH_W-1:0] hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            lo_reg    <= '0;
            hi_reg    <= '0;
        end else if (ctl.clear) begin
            found_reg <= 1'b0;
            lo_reg    <= '0;
            hi_reg    <= '0;
        end else if (ctl.en) begin
            found_reg <= 1'b1;
            if (!found_reg || near_in < lo_reg) begin
                lo_reg <= near_in;
            end
            if (!found_reg || far_in > hi_reg) begin
                hi_reg <= far_in;
            end
        end
    end

    assign found = found_reg;
    assign lo    = lo_reg;
    assign hi    = hi_reg;

endmodule

FILE: sv/range_image_neighbor_query_unit.sv
// ----------------------------------------------------------------------------
// range_image_neighbor_query_unit
// Range-image cell store with vertical support and neighbor depth range
// queries, served by a small sequencer over one single-port cell memory.
// ----------------------------------------------------------------------------
// After reset the unit clears all COLUMNS*ROWS cells and takes no item until
// that pass ends; configuration writes are taken at any time. Items are then
// taken one at a time, one cell memory read per cycle setting the pace. A
// write goes through setup, address multiply and memory write; setup sends it
// back to idle if the cell is out of range or the kind unknown. A vertical
// support query scans rows floor to min(ceiling, ROWS-1) of its column and a
// neighbor range query the in-range window cells, at most (2R+1)^2 for radius
// R. Both skip the scan if the cell is out of range, the vertical one also if
// the start row lies outside the floor-ceiling span. A finished result waits
// in an output register, so the next item is taken while it is still held; a
// query that finishes while that register is still full waits until it drains.
// ----------------------------------------------------------------------------
module range_image_neighbor_query_unit #(
    parameter int COLUMNS = rinq_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = rinq_pkg::ROWS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rinq_pkg::KIND_W-1:0]       s_kind,
    input  logic [rinq_pkg::COL_IN_W-1:0]     s_col,
    input  logic [rinq_pkg::ROW_IN_W-1:0]     s_row,
    input  logic                              s_cell_occupied,
    input  logic [rinq_pkg::DEPTH_W-1:0]      s_cell_min_depth,
    input  logic [rinq_pkg::DEPTH_W-1:0]      s_cell_max_depth,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_isolated,
    output logic                              m_range_found,
    output logic [rinq_pkg::DEPTH_W-1:0]      m_near_depth,
    output logic [rinq_pkg::DEPTH_W-1:0]      m_far_depth,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rinq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rinq_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(CELLS);
    localparam int CXW   = ((CW > rinq_pkg::COL_IN_W) ? CW : rinq_pkg::COL_IN_W) + 1;
    localparam int RXW   = ((RW > rinq_pkg::ROW_IN_W) ? RW : rinq_pkg::ROW_IN_W) + 1;
    localparam int DW    = rinq_pkg::DEPTH_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    state_t                          state_reg;
    rinq_pkg::kind_t                 kind_reg;
    logic [rinq_pkg::COL_IN_W-1:0]   col_in_reg;
    logic [rinq_pkg::ROW_IN_W-1:0]   row_in_reg;
    logic                            occ_in_reg;
    logic [DW-1:0]                   near_in_reg;
    logic [DW-1:0]                   far_in_reg;
    logic                            col_ok_reg;
    logic                            row_ok_reg;

    logic [rinq_pkg::FOV_W-1:0]      floor_reg;
    logic [rinq_pkg::FOV_W-1:0]      ceil_reg;
    logic [rinq_pkg::RADIUS_W-1:0]   radius_reg;

    logic [CW-1:0]                   col_cnt_reg;
    logic [CW-1:0]                   col_hi_reg;
    logic [RW-1:0]                   row_cnt_reg;
    logic [RW-1:0]                   row_lo_reg;
    logic [RW-1:0]                   row_hi_reg;
    logic [AW-1:0]                   base_reg;
    logic [AW-1:0]                   base_next;
    logic [AW-1:0]                   clr_cnt_reg;

    logic                            rd_vld_reg;
    logic [RW-1:0]                   rd_row_reg;
    logic                            down_reg;
    logic                            up_reg;
    logic                            bad_reg;

    logic                            m_valid_reg;
    logic                            m_isolated_reg;
    logic                            m_range_found_reg;
    logic [DW-1:0]                   m_near_reg;
    logic [DW-1:0]                   m_far_reg;

    logic                            in_range;
    logic [CXW-1:0]                  c_ext;
    logic [CXW-1:0]                  n_c;
    logic [CXW-1:0]                  win_col_lo;
    logic [CXW-1:0]                  win_col_hi_raw;
    logic [CXW-1:0]                  win_col_hi;
    logic [RXW-1:0]                  r_ext;
    logic [RXW-1:0]                  n_r;
    logic [RXW-1:0]                  win_row_lo;
    logic [RXW-1:0]                  win_row_hi_raw;
    logic [RXW-1:0]                  win_row_hi;
    logic [RXW-1:0]                  floor_ext;
    logic [RXW-1:0]                  ceil_ext;
    logic [RXW-1:0]                  ceil_clip;
    logic                            vert_empty;
    logic                            rd_at_or_below;
    logic                            rd_at_or_above;

    logic                            ram_we;
    logic [AW-1:0]                   ram_addr;
    logic [rinq_pkg::CELL_W-1:0]     ram_wdata;
    logic [rinq_pkg::CELL_W-1:0]     ram_rdata;
    logic                            rd_occ;
    logic [DW-1:0]                   rd_near;
    logic [DW-1:0]                   rd_far;

    rinq_pkg::acc_ctl_t              acc_ctl;
    logic                            acc_found;
    logic [DW-1:0]                   acc_lo;
    logic [DW-1:0]                   acc_hi;

    // window and scan limits from the held item
    assign in_range       = col_ok_reg & row_ok_reg;
    assign c_ext          = CXW'(col_in_reg);
    assign n_c            = CXW'(radius_reg);
    assign win_col_lo     = (c_ext >= n_c) ? c_ext - n_c : '0;
    assign win_col_hi_raw = c_ext + n_c;
    assign win_col_hi     = (win_col_hi_raw > CXW'(COLUMNS - 1)) ? CXW'(COLUMNS - 1)
                                                                  : win_col_hi_raw;
    assign r_ext          = RXW'(row_in_reg);
    assign n_r            = RXW'(radius_reg);
    assign win_row_lo     = (r_ext >= n_r) ? r_ext - n_r : '0;
    assign win_row_hi_raw = r_ext + n_r;
    assign win_row_hi     = (win_row_hi_raw > RXW'(ROWS - 1)) ? RXW'(ROWS - 1)
                                                              : win_row_hi_raw;
    assign floor_ext      = RXW'(floor_reg);
    assign ceil_ext       = RXW'(ceil_reg);
    assign ceil_clip      = (ceil_ext > RXW'(ROWS - 1)) ? RXW'(ROWS - 1) : ceil_ext;
    assign vert_empty     = (floor_ext > r_ext) || (ceil_clip < r_ext);

    assign base_next = AW'(AW'(col_cnt_reg) * AW'(ROWS));

    // cell memory port
    assign ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
    assign ram_addr  = (state_reg == ST_CLEAR) ? clr_cnt_reg
                                               : base_reg + AW'(row_cnt_reg);
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0
                                               : {occ_in_reg, near_in_reg, far_in_reg};

    rinq_ram #(
        .WIDTH (rinq_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_occ  = ram_rdata[rinq_pkg::CELL_W-1];
    assign rd_near = ram_rdata[2*DW-1:DW];
    assign rd_far  = ram_rdata[DW-1:0];

    assign rd_at_or_below = RXW'(rd_row_reg) <= r_ext;
    assign rd_at_or_above = RXW'(rd_row_reg) >= r_ext;

    assign acc_ctl.clear = (state_reg == ST_SETUP);
    assign acc_ctl.en    = rd_vld_reg && rd_occ && (kind_reg == rinq_pkg::KIND_RANGE);

    rinq_acc u_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (acc_ctl),
        .near_in (rd_near),
        .far_in  (rd_far),
        .found   (acc_found),
        .lo      (acc_lo),
        .hi      (acc_hi)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            floor_reg   <= rinq_pkg::FLOOR_RESET;
            ceil_reg    <= rinq_pkg::CEILING_RESET;
            radius_reg  <= rinq_pkg::RADIUS_RESET;
            down_reg    <= 1'b0;
            up_reg      <= 1'b0;
            bad_reg     <= 1'b0;
            kind_reg    <= rinq_pkg::KIND_WRITE;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    rinq_pkg::CFG_FLOOR:   floor_reg  <= cfg_data;
                    rinq_pkg::CFG_CEILING: ceil_reg   <= cfg_data;
                    rinq_pkg::CFG_RADIUS:  radius_reg <= cfg_data[rinq_pkg::RADIUS_W-1:0];
                    default: ;
                endcase
            end

            if (state_reg == ST_RESULT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            rd_vld_reg <= (state_reg == ST_SCAN);
            rd_row_reg <= row_cnt_reg;

            if (rd_vld_reg && rd_occ && kind_reg == rinq_pkg::KIND_VERT) begin
                down_reg <= down_reg | rd_at_or_below;
                up_reg   <= up_reg | rd_at_or_above;
            end

            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(CELLS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        kind_reg    <= rinq_pkg::kind_t'(s_kind);
                        col_in_reg  <= s_col;
                        row_in_reg  <= s_row;
                        occ_in_reg  <= s_cell_occupied;
                        near_in_reg <= s_cell_min_depth;
                        far_in_reg  <= s_cell_max_depth;
                        col_ok_reg  <= int'(s_col) < COLUMNS;
                        row_ok_reg  <= int'(s_row) < ROWS;
                        state_reg   <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    down_reg <= 1'b0;
                    up_reg   <= 1'b0;
                    case (kind_reg)
                        rinq_pkg::KIND_WRITE: begin
                            col_cnt_reg <= CW'(col_in_reg);
                            row_cnt_reg <= RW'(row_in_reg);
                            state_reg   <= in_range ? ST_MUL : ST_IDLE;
                        end
                        rinq_pkg::KIND_VERT: begin
                            bad_reg     <= !in_range || vert_empty;
                            col_cnt_reg <= CW'(col_in_reg);
                            col_hi_reg  <= CW'(col_in_reg);
                            row_cnt_reg <= RW'(floor_ext);
                            row_lo_reg  <= RW'(floor_ext);
                            row_hi_reg  <= RW'(ceil_clip);
                            state_reg   <= (!in_range || vert_empty) ? ST_RESULT : ST_MUL;
                        end
                        rinq_pkg::KIND_RANGE: begin
                            bad_reg     <= !in_range;
                            col_cnt_reg <= CW'(win_col_lo);
                            col_hi_reg  <= CW'(win_col_hi);
                            row_cnt_reg <= RW'(win_row_lo);
                            row_lo_reg  <= RW'(win_row_lo);
                            row_hi_reg  <= RW'(win_row_hi);
                            state_reg   <= in_range ? ST_MUL : ST_RESULT;
                        end
                        default: begin
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end
                ST_MUL: begin
                    base_reg  <= base_next;
                    state_reg <= (kind_reg == rinq_pkg::KIND_WRITE) ? ST_WRITE : ST_SCAN;
                end
                ST_WRITE: begin
                    state_reg <= ST_IDLE;
                end
                ST_SCAN: begin
                    if (row_cnt_reg == row_hi_reg) begin
                        if (col_cnt_reg == col_hi_reg) begin
                            state_reg <= ST_DRAIN;
                        end else begin
                            col_cnt_reg <= col_cnt_reg + 1'b1;
                            base_reg    <= base_reg + AW'(ROWS);
                            row_cnt_reg <= row_lo_reg;
                        end
                    end else begin
                        row_cnt_reg <= row_cnt_reg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (!m_valid_reg || m_ready) begin
                        if (kind_reg == rinq_pkg::KIND_VERT) begin
                            m_isolated_reg    <= bad_reg || !(down_reg && up_reg);
                            m_range_found_reg <= 1'b0;
                            m_near_reg        <= '0;
                            m_far_reg         <= '0;
                        end else begin
                            m_isolated_reg    <= 1'b0;
                            m_range_found_reg <= acc_found && !bad_reg;
                            m_near_reg        <= bad_reg ? '0 : acc_lo;
                            m_far_reg         <= bad_reg ? '0 : acc_hi;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_isolated    = m_isolated_reg;
    assign m_range_found = m_range_found_reg;
    assign m_near_depth  = m_near_reg;
    assign m_far_depth   = m_far_reg;

    a_scan_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> (row_cnt_reg <= row_hi_reg) && (col_cnt_reg <= col_hi_reg))
        else $error("scan counter beyond window limit");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT && m_valid_reg && !m_ready)
        |=> (state_reg == ST_RESULT && m_valid_reg))
        else $error("result lost while output stalled");

    a_empty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_range_found_reg) |-> (m_near_reg == '0 && m_far_reg == '0))
        else $error("depths nonzero with no occupied neighbor");

    a_kind_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_range_found_reg) |-> !m_isolated_reg)
        else $error("range result carries isolated flag");

endmodule
